@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/deq_pkg.sv @@
package deq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OCC_W    = 5;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_QUERY      = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic                     is_empty;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

  // Port requests from the control unit to the element memory.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr_front;
    logic [IDX_W-1:0]  raddr_back;
  } mem_req_t;

  // Slot index plus an offset, wrapped around the ring.
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(idx) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return IDX_W'(sum);
  endfunction

endpackage

@@ hdl/deq_store.sv @@
module deq_store (
  input  logic                          clk_i,
  input  deq_pkg::mem_req_t             mem_req_i,
  output logic [deq_pkg::DATA_W-1:0]    rdata_front_o,
  output logic [deq_pkg::DATA_W-1:0]    rdata_back_o
);

  logic [deq_pkg::DATA_W-1:0] mem_q [deq_pkg::CAPACITY];

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
  end

  // Registered reads; hold the last data while no read is issued.
  always_ff @(posedge clk_i) begin
    if (mem_req_i.re) begin
      rdata_front_o <= mem_q[mem_req_i.raddr_front];
      rdata_back_o  <= mem_q[mem_req_i.raddr_back];
    end
  end

endmodule

@@ hdl/deq_ctrl.sv @@
module deq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  deq_pkg::req_t               in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output deq_pkg::rsp_t               out_rsp_o,
  output deq_pkg::mem_req_t           mem_req_o,
  input  logic [deq_pkg::DATA_W-1:0]  rdata_front_i,
  input  logic [deq_pkg::DATA_W-1:0]  rdata_back_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [deq_pkg::IDX_W-1:0]  front_q, front_d;
  logic [deq_pkg::CNT_W-1:0]  count_q, count_d;
  deq_pkg::status_e           status_q, status_d;
  logic                       out_valid_q, out_valid_d;
  deq_pkg::rsp_t              out_rsp_q, out_rsp_d;
  logic                       accept;
  logic                       load;
  logic                       is_empty;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load        = (state_q == S_LOAD) && (!out_valid_q || out_ready_i);
  assign is_empty    = (count_q == '0);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Apply the request to the pointers and issue the memory write.
  always_comb begin
    front_d         = front_q;
    count_d         = count_q;
    status_d        = status_q;
    mem_req_o       = '0;
    mem_req_o.wdata = in_req_i.value;
    if (accept) begin
      status_d = deq_pkg::ST_OK;
      case (in_req_i.op) inside
        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
          if (count_q == deq_pkg::CNT_W'(deq_pkg::CAPACITY)) begin
            status_d = deq_pkg::ST_FULL;
          end else begin
            mem_req_o.we = 1'b1;
            count_d      = count_q + 1'b1;
            if (in_req_i.op == deq_pkg::OP_PUSH_FRONT) begin
              front_d = (front_q == '0) ? deq_pkg::IDX_W'(deq_pkg::CAPACITY - 1)
                                        : front_q - 1'b1;
              mem_req_o.waddr = front_d;
            end else begin
              mem_req_o.waddr = deq_pkg::slot_add(front_q, count_q);
            end
          end
        end
        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
          if (is_empty) begin
            status_d = deq_pkg::ST_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
            if (in_req_i.op == deq_pkg::OP_POP_FRONT) begin
              front_d = deq_pkg::slot_add(front_q, deq_pkg::CNT_W'(1));
            end
          end
        end
        default: begin
        end
      endcase
    end
    // The write lands at the end of the accept cycle; the read is issued in the following S_READ state.
    if (state_q == S_READ) begin
      mem_req_o.re          = 1'b1;
      mem_req_o.raddr_front = front_q;
      mem_req_o.raddr_back  = is_empty ? front_q
                                       : deq_pkg::slot_add(front_q, count_q - 1'b1);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_READ;
      S_READ:  state_d = S_LOAD;
      S_LOAD:  if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d           = 1'b1;
      out_rsp_d.status      = status_q;
      out_rsp_d.front_value = is_empty ? '0 : rdata_front_i;
      out_rsp_d.back_value  = is_empty ? '0 : rdata_back_i;
      out_rsp_d.is_empty    = is_empty;
      out_rsp_d.occupancy   = deq_pkg::OCC_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      status_q    <= deq_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

endmodule

@@ hdl/double_ended_queue.sv @@
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o | in_req_i  (deq_pkg::req_t: op, value)
// out     | output    | out_valid_o/ out_ready_i| out_rsp_o (deq_pkg::rsp_t)
//
// A request is accepted only while idle, then steps through accept and write
// the element memory, read front and back slots, load the result; the single
// write port and registered reads of the element memory set these steps.
// Reset clears the pointers, the count and the output valid; memory contents
// stay undefined and are never used before written. A stalled output holds
// the result; the next request may enter but waits at load until it is taken.
module double_ended_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  deq_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output deq_pkg::rsp_t out_rsp_o
);

  deq_pkg::mem_req_t          mem_req;
  logic [deq_pkg::DATA_W-1:0] rdata_front;
  logic [deq_pkg::DATA_W-1:0] rdata_back;

  // Pointer, count and sequencing; owns the output register.
  deq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_req_i      (in_req_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_rsp_o     (out_rsp_o),
    .mem_req_o     (mem_req),
    .rdata_front_i (rdata_front),
    .rdata_back_i  (rdata_back)
  );

  // Ring buffer storage: one write port, two registered read ports.
  deq_store u_store (
    .clk_i         (clk_i),
    .mem_req_i     (mem_req),
    .rdata_front_o (rdata_front),
    .rdata_back_o  (rdata_back)
  );

endmodule

@@ hdl/deq_checker.sv @@
`include "assert_macros.svh"

module deq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input deq_pkg::rsp_t out_rsp_i
);

  logic stalled;
  logic occ_in_range;
  logic empty_agrees;
  logic values_zero;
  logic pop_on_empty;

  assign stalled      = out_valid_i && !out_ready_i;
  assign occ_in_range = (out_rsp_i.occupancy <= deq_pkg::OCC_W'(deq_pkg::CAPACITY));
  assign empty_agrees = (out_rsp_i.is_empty == (out_rsp_i.occupancy == '0));
  assign values_zero  = (out_rsp_i.front_value == '0) && (out_rsp_i.back_value == '0);
  assign pop_on_empty = out_valid_i && (out_rsp_i.status == deq_pkg::ST_EMPTY);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_i && $stable(out_rsp_i))
  `ASSERT_NOW(a_occ_range, clk_i, rst_ni, out_valid_i, occ_in_range)
  `ASSERT_NOW(a_empty_flag, clk_i, rst_ni, out_valid_i, empty_agrees)
  `ASSERT_NOW(a_empty_zero, clk_i, rst_ni, out_valid_i && out_rsp_i.is_empty, values_zero)
  `ASSERT_NOW(a_pop_empty, clk_i, rst_ni, pop_on_empty, out_rsp_i.is_empty)

endmodule

bind double_ended_queue deq_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_i   (out_rsp_o)
);
